// File: rtl/pba_pkg.sv
`timescale 1ns / 1ps
package pba_pkg;

  // Free stack geometry
  localparam int FREE_DEPTH = 256;
  localparam int FREE_AW    = $clog2(FREE_DEPTH);
  localparam int FREE_CW    = FREE_AW + 1;

  localparam int ADDR_W  = 64;
  localparam int PAGE_SH = 12;
  localparam int PAGE_W  = ADDR_W - PAGE_SH;

  // Request actions
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_V2P   = 2'd2;
  localparam logic [1:0] ACT_P2V   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_PAGE = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BOTTOM = 2'd0;
  localparam logic [1:0] CFG_TOP    = 2'd1;
  localparam logic [1:0] CFG_BASE   = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
  } pba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
  } pba_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } pba_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } pba_cmd_t;

  typedef struct packed {
    logic out_free;
  } pba_sts_t;

endpackage

// File: rtl/pba_ram.sv
`timescale 1ns / 1ps
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pba_datapath.sv
`timescale 1ns / 1ps
module pba_datapath
  import pba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pba_cmd_t    cmd,
  output pba_sts_t    sts,
  input  pba_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pba_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam logic [FREE_CW-1:0] FREE_FULL = FREE_CW'(FREE_DEPTH);

  // Configuration, kept as page numbers
  logic [PAGE_W-1:0]  bottom_pg_r, bottom_pg_nxt;
  logic [PAGE_W-1:0]  top_pg_r, top_pg_nxt;
  logic [PAGE_W-1:0]  base_pg_r, base_pg_nxt;
  // Bump pointer: virtual page and its physical page
  logic [PAGE_W-1:0]  next_page_r, next_page_nxt;
  logic [PAGE_W-1:0]  phys_page_r, phys_page_nxt;
  logic [FREE_CW-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Request payload captured at accept
  logic [1:0]         act_r;
  logic [ADDR_W-1:0]  diff_r;
  logic               zero_r;
  logic [PAGE_W-1:0]  addr_pg_r;
  pba_out_t           out_r, out_nxt;

  logic [ADDR_W-1:0]  cfg_round;
  logic [ADDR_W-1:0]  load_off;
  logic               ram_we;
  logic [FREE_AW-1:0] ram_waddr;
  logic [FREE_AW-1:0] ram_raddr;
  logic [PAGE_W-1:0]  ram_rdata;

  assign cfg_round = cfg_wdata + ADDR_W'(12'hFFF);
  assign load_off  = (in_data.action == ACT_V2P) ? {base_pg_r, PAGE_SH'(0)}
                                                 : {bottom_pg_r, PAGE_SH'(0)};
  // Read the stack top ahead of execution
  assign ram_raddr = count_r[FREE_AW-1:0] - FREE_AW'(1);
  assign ram_waddr = count_r[FREE_AW-1:0];

  pba_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (FREE_DEPTH)
  ) u_free_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (addr_pg_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Execute the request, then apply configuration writes
  always_comb begin
    bottom_pg_nxt = bottom_pg_r;
    top_pg_nxt    = top_pg_r;
    base_pg_nxt   = base_pg_r;
    next_page_nxt = next_page_r;
    phys_page_nxt = phys_page_r;
    count_nxt     = count_r;
    ram_we        = 1'b0;
    out_nxt       = out_r;

    if (cmd.exec) begin
      out_nxt.result_address = '0;
      out_nxt.status         = STAT_OK;
      case (act_r)
        ACT_ALLOC: begin
          if (base_pg_r == '0) begin
            out_nxt.status = STAT_NO_PAGE;
          end else if (count_r != '0) begin
            count_nxt              = count_r - FREE_CW'(1);
            out_nxt.result_address = {ram_rdata, PAGE_SH'(0)};
          end else if (phys_page_r < top_pg_r) begin
            out_nxt.result_address = {next_page_r, PAGE_SH'(0)};
            next_page_nxt          = next_page_r + PAGE_W'(1);
            phys_page_nxt          = phys_page_r + PAGE_W'(1);
          end else begin
            out_nxt.status = STAT_NO_PAGE;
          end
        end
        ACT_FREE: begin
          if (count_r != FREE_FULL) begin
            ram_we    = 1'b1;
            count_nxt = count_r + FREE_CW'(1);
          end else begin
            out_nxt.status = STAT_FULL;
          end
        end
        ACT_V2P: begin
          out_nxt.result_address = zero_r ? '0 : {bottom_pg_r, PAGE_SH'(0)} + diff_r;
        end
        ACT_P2V: begin
          out_nxt.result_address = zero_r ? '0 : {base_pg_r, PAGE_SH'(0)} + diff_r;
        end
        default: begin
          out_nxt.status = STAT_OK;
        end
      endcase
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_BOTTOM: bottom_pg_nxt = cfg_round[ADDR_W-1:PAGE_SH];
        CFG_TOP:    top_pg_nxt    = cfg_wdata[ADDR_W-1:PAGE_SH];
        CFG_BASE:   base_pg_nxt   = cfg_round[ADDR_W-1:PAGE_SH];
        default:    bottom_pg_nxt = bottom_pg_r;
      endcase
      // Any valid register write restarts the pointer and empties the stack
      if (cfg_index inside {CFG_BOTTOM, CFG_TOP, CFG_BASE}) begin
        next_page_nxt = base_pg_nxt;
        phys_page_nxt = bottom_pg_nxt;
        count_nxt     = '0;
      end
    end
  end

  // Output register: set on execute, drop on handoff
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_pg_r <= '0;
      top_pg_r    <= '0;
      base_pg_r   <= '0;
      next_page_r <= '0;
      phys_page_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bottom_pg_r <= bottom_pg_nxt;
      top_pg_r    <= top_pg_nxt;
      base_pg_r   <= base_pg_nxt;
      next_page_r <= next_page_nxt;
      phys_page_r <= phys_page_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture request payload; precompute the translation offset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_data.action;
      diff_r    <= in_data.address - load_off;
      zero_r    <= (in_data.address == '0);
      addr_pg_r <= in_data.address[ADDR_W-1:PAGE_SH];
    end
    out_r <= out_nxt;
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// File: rtl/pba_ctrl.sv
`timescale 1ns / 1ps
module pba_ctrl
  import pba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pba_sts_t sts,
  output pba_cmd_t cmd
);

  pba_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/page_bump_allocator_core.sv
`timescale 1ns / 1ps
// A result is registered in the execute state entered after its request is
// accepted, later only while the previous result is still held by out_stall.
// The block takes no new request until execute is done; the stack top is read
// at the accept edge and used in the execute state, which takes no request.
// Reset (rst_n, synchronous): clears registers, bump pointer, stack count and
// output valid. Stack memory contents are not cleared.
module page_bump_allocator_core
  import pba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pba_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pba_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  pba_cmd_t cmd;
  pba_sts_t sts;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pba_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

`ifndef SYNTHESIS
  // Execute always lands a result in the output register
  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("execute did not produce a result");

  // Load and execute never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec))
    else $error("load and execute in the same cycle");

  // After an accept the block is busy for the execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one executes");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_NO_PAGE ||
                   out_data.status == STAT_FULL))
    else $error("undefined status code");
`endif

endmodule

// File: sim/page_alloc_checker.sv
`timescale 1ns / 1ps
module page_alloc_checker
  import pba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  pba_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  pba_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          results_owed
);

  localparam logic [ADDR_W-1:0] PAGE_BYTES = 64'd4096;
  localparam logic [ADDR_W-1:0] PAGE_OFFS  = 64'hFFF;

  // Mirror of the window registers and allocator state
  logic [ADDR_W-1:0] win_bottom;
  logic [ADDR_W-1:0] win_top;
  logic [ADDR_W-1:0] win_base;
  logic [PAGE_W-1:0] bump_page;
  logic [PAGE_W-1:0] freed_pages [FREE_DEPTH];
  int                freed_depth;
  pba_out_t          owed_q [$];
  int                mismatches = 0;

  function automatic logic [ADDR_W-1:0] round_up_page(input logic [ADDR_W-1:0] x);
    return (x + PAGE_OFFS) & ~PAGE_OFFS;
  endfunction

  // Restart the bump pointer at the base page and empty the free stack
  task automatic restart_window();
    logic [ADDR_W-1:0] base_r;
    base_r = round_up_page(win_base);
    bump_page = base_r[ADDR_W-1:PAGE_SH];
    freed_depth = 0;
  endtask

  // Work out the result of one request and advance the allocator state
  function automatic pba_out_t predict_page_result(input pba_in_t req);
    logic [ADDR_W-1:0] bottom;
    logic [ADDR_W-1:0] top;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;
    pba_out_t          res;
    bottom = round_up_page(win_bottom);
    top    = win_top & ~PAGE_OFFS;
    base   = round_up_page(win_base);
    res    = '{result_address: '0, status: STAT_OK};
    case (req.action)
      ACT_ALLOC: begin
        if (base == '0) begin
          res.status = STAT_NO_PAGE;
        end else if (freed_depth > 0) begin
          freed_depth--;
          res.result_address = {freed_pages[freed_depth[FREE_AW-1:0]], {PAGE_SH{1'b0}}};
        end else begin
          va = {bump_page, {PAGE_SH{1'b0}}};
          pa = bottom + (va - base);
          // only pages that end at or below the page-aligned top are handed out
          if (pa <= top && top - pa >= PAGE_BYTES) begin
            res.result_address = va;
            bump_page = bump_page + PAGE_W'(1);
          end else begin
            res.status = STAT_NO_PAGE;
          end
        end
      end
      ACT_FREE: begin
        if (freed_depth < FREE_DEPTH) begin
          freed_pages[freed_depth[FREE_AW-1:0]] = req.address[ADDR_W-1:PAGE_SH];
          freed_depth++;
        end else begin
          res.status = STAT_FULL;
        end
      end
      ACT_V2P: begin
        if (req.address != '0) res.result_address = bottom + (req.address - base);
      end
      ACT_P2V: begin
        if (req.address != '0) res.result_address = base + (req.address - bottom);
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    pba_out_t want;
    if (!rst_n) begin
      win_bottom = '0;
      win_top    = '0;
      win_base   = '0;
      restart_window();
      owed_q.delete();
    end else begin
      // Compare a delivered result with the oldest owed one
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          if (mismatches < 10)
            $display("%t: unexpected result addr %h status %0d", $realtime,
                     out_data.result_address, out_data.status);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (out_data.result_address !== want.result_address ||
              out_data.status !== want.status) begin
            if (mismatches < 10)
              $display("%t: result mismatch: expected addr %h status %0d, got addr %h status %0d",
                       $realtime, want.result_address, want.status,
                       out_data.result_address, out_data.status);
            mismatches++;
          end
        end
      end
      // Track register writes; a spare index changes nothing
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOTTOM: begin
            win_bottom = cfg_wdata;
            restart_window();
          end
          CFG_TOP: begin
            win_top = cfg_wdata;
            restart_window();
          end
          CFG_BASE: begin
            win_base = cfg_wdata;
            restart_window();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) owed_q.push_back(predict_page_result(in_data));
    end
    fail_count   <= mismatches;
    results_owed <= owed_q.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb
  import pba_pkg::*;
();

  localparam logic [1:0]  CFG_SPARE = 2'd3;
  localparam logic [63:0] ALL_ONES  = '1;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pba_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pba_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_BOTTOM;
  logic [63:0] cfg_wdata = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int fail_total;
  int results_owed;

  always #5 clk = ~clk;

  page_bump_allocator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  page_alloc_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_total),
    .results_owed (results_owed)
  );

  // Hold off the result channel at random
  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(0, 99)) < rx_idle_pct);
  end

  // Present one request, idling cycle by cycle at random, and hold it until taken
  task automatic send_req(input logic [1:0] act, input logic [63:0] addr);
    while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, address: addr};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Load all three window registers, now and then poking the spare index too
  task automatic write_regs(input logic [63:0] bottom, input logic [63:0] top,
                            input logic [63:0] base);
    wait_idle(3);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BOTTOM;
    cfg_wdata <= bottom;
    @(posedge clk);
    cfg_index <= CFG_TOP;
    cfg_wdata <= top;
    @(posedge clk);
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    if ($urandom_range(0, 3) == 0) begin
      cfg_index <= CFG_SPARE;
      cfg_wdata <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Choose a new window: mostly a few pages, sometimes wrapping, inverted or disabled
  task automatic pick_window();
    logic [63:0] bottom;
    logic [63:0] base;
    int          pages;
    case ($urandom_range(0, 6))
      0: write_regs(ALL_ONES, ALL_ONES, 64'hFFFF_FFFF_FFFF_E001);
      1: begin
        bottom = {1'b1, 31'($urandom_range(0, 32'h7FFF_FFFF)), $urandom};
        write_regs(bottom, bottom - 64'h10_0000, {$urandom, $urandom});
      end
      2: write_regs({$urandom, $urandom}, {$urandom, $urandom}, '0);
      default: begin
        bottom = {$urandom, $urandom};
        base   = {$urandom, $urandom};
        pages  = $urandom_range(1, 12);
        write_regs(bottom,
                   bottom + (64'(pages) << PAGE_SH) + 64'($urandom_range(0, 4095)),
                   base);
      end
    endcase
  endtask

  task automatic random_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      send_req(ACT_ALLOC, pick_addr());
    else if (r < 65) send_req(ACT_FREE, pick_addr());
    else if (r < 83) send_req(ACT_V2P, pick_addr());
    else             send_req(ACT_P2V, pick_addr());
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) pick_window();
      random_req();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Base of zero: no page even with a freed one on the stack
    send_req(ACT_ALLOC, '0);
    send_req(ACT_FREE, 64'h0000_0000_0000_5000);
    send_req(ACT_ALLOC, ALL_ONES);
    send_req(ACT_V2P, '0);
    send_req(ACT_P2V, 64'h1234);

    // Four-page window: bump to the last page, then exhaust
    write_regs(64'h1000_0001, 64'h1000_5FFF, 64'hFFFF_8000_0000_0001);
    repeat (5) send_req(ACT_ALLOC, '0);
    // Unaligned free, free of zero, then pop both back
    send_req(ACT_FREE, 64'hFFFF_8000_0000_1ABC);
    send_req(ACT_FREE, '0);
    repeat (3) send_req(ACT_ALLOC, '0);
    send_req(ACT_V2P, ALL_ONES);
    send_req(ACT_V2P, '0);
    send_req(ACT_P2V, 64'h1000_1000);
    send_req(ACT_P2V, ALL_ONES);
    send_req(ACT_P2V, '0);

    // Base at the top page: the bump pointer wraps to page zero
    write_regs(ALL_ONES, ALL_ONES, 64'hFFFF_FFFF_FFFF_E001);
    repeat (3) send_req(ACT_ALLOC, '0);

    run_phase(26, 62, 70);
    run_phase(62, 26, 70);
    run_phase(0, 0, 24);

    // Fill the free stack past its depth, then drain a few pages
    pick_window();
    repeat (FREE_DEPTH + 4) send_req(ACT_FREE, pick_addr());
    repeat (6) send_req(ACT_ALLOC, pick_addr());

    wait_idle(10);
    if (fail_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: page_bump_allocator_core.f
rtl/pba_pkg.sv
rtl/pba_ram.sv
rtl/pba_datapath.sv
rtl/pba_ctrl.sv
rtl/page_bump_allocator_core.sv
sim/page_alloc_checker.sv
sim/tb.sv
